/* hw/rtl/apr_pkg.sv */
`default_nettype none
package apr_pkg;

	// default sizes
	localparam int MAX_PIVOTS_DEF     = 64;
	localparam int MAX_TOKENS_DEF     = 64;
	localparam int PROB_FRAC_BITS_DEF = 15;

	localparam logic [15:0] VAL_MAX = 16'hFFFF;

	// shared divider sizes: numerator, divisor, step counter
	localparam int DIV_NW = 32;
	localparam int DIV_DW = 16;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	typedef enum logic [2:0] {
		REQ_LOAD_FIRST  = 3'd0,
		REQ_LOAD_SECOND = 3'd1,
		REQ_LOAD_A      = 3'd2,
		REQ_LOAD_B      = 3'd3,
		REQ_COMPUTE     = 3'd4,
		REQ_READ_C      = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NO_OVERLAP    = 2'd1,
		ST_NOT_EXHAUSTED = 2'd2
	} status_code_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_MCHK,
		S_MEVAL,
		S_MTRD,
		S_MTDAT,
		S_MTSTART,
		S_MTDIV,
		S_MADV,
		S_LCHK,
		S_LTCHK,
		S_LBDAT,
		S_LDIV,
		S_LQRD,
		S_LQWR,
		S_PT,
		S_PS,
		S_PQ,
		S_PMUL,
		S_PACC,
		S_PWR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [5:0]  row_index;
		logic [5:0]  col_index;
		logic [15:0] range_begin;
		logic [15:0] range_end;
		logic [15:0] prob_value;
		logic [6:0]  first_pivot_count;
		logic [6:0]  second_pivot_count;
		logic [6:0]  source_token_count;
		logic [6:0]  target_token_count;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] result_value;
		logic [1:0]  status_code;
	} rsp_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/alignment_pivot_remap.sv */
// Pivot alignment remapping, one sentence at a time.
// Request channel: req_valid / req_stall / req_data. Response channel:
// rsp_valid / rsp_stall / rsp_data. A request moves when valid is high and
// stall is low.
// Load requests (ranges, A, B) are written as they are accepted and give no response.
// A read of C gives its response from the registered read of the C memory
// through the response register; no new request is taken while that read is in flight.
// A compute request holds req_stall high while it works: a clearing sweep of
// MAX_TOKENS * max(MAX_PIVOTS, MAX_TOKENS) entries (4096 by default) over R
// and C; per range pair, one serial division per target on a partial overlap,
// a direct add per target on an exact match, only an advance without overlap;
// per leftover second range, one division per target, spread over the first
// pivots; for the product, per target and source, a multiply-accumulate over
// the first pivots; then the loop exit. One status response follows. All
// range and matrix data sits in single-port-read synchronous memories, read
// one entry a cycle and written back.
// Reset clears the control; a read of C before the first compute gives 0.
// When the receiver stalls, the response register holds and further
// requests are held off until it is taken.
`default_nettype none
module alignment_pivot_remap #(
	parameter int MAX_PIVOTS     = apr_pkg::MAX_PIVOTS_DEF,
	parameter int MAX_TOKENS     = apr_pkg::MAX_TOKENS_DEF,
	parameter int PROB_FRAC_BITS = apr_pkg::PROB_FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire apr_pkg::req_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output apr_pkg::rsp_t       rsp_data
);
	import apr_pkg::*;

	localparam int PW    = $clog2(MAX_PIVOTS);
	localparam int TW    = $clog2(MAX_TOKENS);
	localparam int PCW   = $clog2(MAX_PIVOTS + 1);
	localparam int TCW   = $clog2(MAX_TOKENS + 1);
	localparam int MDEP  = MAX_TOKENS * MAX_PIVOTS;
	localparam int CDEP  = MAX_TOKENS * MAX_TOKENS;
	localparam int AWM   = $clog2(MDEP);
	localparam int AWC   = $clog2(CDEP);
	localparam int CLRN  = (MDEP > CDEP) ? MDEP : CDEP;
	localparam int CLW   = $clog2(CLRN);
	localparam int ACCW  = 32 + PW;

	state_t state_q, state_d;

	logic          req_acc;
	logic          rd_s1;
	logic          rd_ok_s1;
	logic          c_valid_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic [PCW-1:0] nf_q, ns2_q, sq_q, qt_q, q_q;
	logic [TCW-1:0] nsrc_q, ntgt_q, t_q, s_q;
	logic [CLW-1:0] clr_q;
	logic           no_ov_q, not_done_q, whole_q;
	logic           fe_eq_q, fe_gt_q;
	logic [15:0]    ov_q, len_q, r_hold_q, gift_q;
	logic [31:0]    prod_q;
	logic [ACCW-1:0] acc_q;
	logic [ACCW-1:0] acc_sh;

	// memory ports
	logic           fr_we, sr_we, a_we, b_we, r_we, c_we;
	logic [PW-1:0]  rng_waddr;
	logic [31:0]    rng_wdata, fr_rd, sr_rd;
	logic [AWM-1:0] a_waddr, b_waddr, a_raddr, b_raddr, r_waddr, r_raddr;
	logic [AWC-1:0] c_waddr, c_raddr;
	logic [15:0]    a_rd, b_rd, r_rd, c_rd, r_wdata, c_wdata;
	logic [PW-1:0]  r_pidx;

	// merge evaluation on the range pair
	logic [15:0] fb, fe, sb, se, left, right;
	logic        ev_exact, ev_overlap;

	logic           div_start;
	logic [31:0]    div_num;
	logic [15:0]    div_den;
	div_stat_t      div_stat;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = 33'(a) + 33'(b);
		return (s > 33'(VAL_MAX)) ? VAL_MAX : s[15:0];
	endfunction

	// request handshake
	assign req_stall = (state_q != S_IDLE) || rd_s1 || (out_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;

	// load decode
	always_comb begin
		fr_we     = 1'b0;
		sr_we     = 1'b0;
		a_we      = 1'b0;
		b_we      = 1'b0;
		rng_waddr = PW'(req_data.row_index);
		rng_wdata = {req_data.range_end, req_data.range_begin};
		a_waddr   = AWM'(req_data.row_index) * AWM'(MAX_TOKENS) + AWM'(req_data.col_index);
		b_waddr   = AWM'(req_data.row_index) * AWM'(MAX_PIVOTS) + AWM'(req_data.col_index);
		if (req_acc) begin
			unique case (req_data.req_type)
				REQ_LOAD_FIRST:  fr_we = 32'(req_data.row_index) < 32'(MAX_PIVOTS);
				REQ_LOAD_SECOND: sr_we = 32'(req_data.row_index) < 32'(MAX_PIVOTS);
				REQ_LOAD_A: a_we = (32'(req_data.row_index) < 32'(MAX_PIVOTS)) &&
					(32'(req_data.col_index) < 32'(MAX_TOKENS));
				REQ_LOAD_B: b_we = (32'(req_data.row_index) < 32'(MAX_TOKENS)) &&
					(32'(req_data.col_index) < 32'(MAX_PIVOTS));
				default: ;
			endcase
		end
	end

	// read addresses follow the loop counters, the C read address the request
	assign r_pidx  = (state_q == S_MTRD) ? sq_q[PW-1:0] : q_q[PW-1:0];
	assign b_raddr = AWM'(t_q[TW-1:0]) * AWM'(MAX_PIVOTS) + AWM'(qt_q[PW-1:0]);
	assign r_raddr = AWM'(t_q[TW-1:0]) * AWM'(MAX_PIVOTS) + AWM'(r_pidx);
	assign a_raddr = AWM'(q_q[PW-1:0]) * AWM'(MAX_TOKENS) + AWM'(s_q[TW-1:0]);
	assign c_raddr = AWC'(req_data.row_index) * AWC'(MAX_TOKENS) + AWC'(req_data.col_index);

	always_comb begin
		fb         = fr_rd[15:0];
		fe         = fr_rd[31:16];
		sb         = sr_rd[15:0];
		se         = sr_rd[31:16];
		left       = (fb > sb) ? fb : sb;
		right      = (fe < se) ? fe : se;
		ev_exact   = (fb == sb) && (fe == se);
		ev_overlap = left < right;
		acc_sh     = acc_q >> PROB_FRAC_BITS;
	end

	// divider operands
	assign div_num = (state_q == S_MTSTART) ? prod_q : 32'(b_rd);
	assign div_den = (state_q == S_MTSTART) ? len_q : 16'(nf_q);

	// next state and memory writes
	always_comb begin
		state_d   = state_q;
		r_we      = 1'b0;
		r_waddr   = AWM'(t_q[TW-1:0]) * AWM'(MAX_PIVOTS) + AWM'(r_pidx);
		r_wdata   = '0;
		c_we      = 1'b0;
		c_waddr   = AWC'(t_q[TW-1:0]) * AWC'(MAX_TOKENS) + AWC'(s_q[TW-1:0]);
		c_wdata   = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && req_data.req_type == REQ_COMPUTE) begin
					state_d = S_CLR;
				end
			end
			S_CLR: begin
				r_we    = 32'(clr_q) < 32'(MDEP);
				c_we    = 32'(clr_q) < 32'(CDEP);
				r_waddr = AWM'(clr_q);
				c_waddr = AWC'(clr_q);
				if (clr_q == CLW'(CLRN - 1)) begin
					state_d = S_MCHK;
				end
			end
			S_MCHK: state_d = (sq_q < nf_q && qt_q < ns2_q) ? S_MEVAL : S_LCHK;
			S_MEVAL: state_d = (ev_exact || ev_overlap) ? S_MTRD : S_MADV;
			S_MTRD: state_d = (t_q < ntgt_q) ? S_MTDAT : S_MADV;
			S_MTDAT: begin
				if (whole_q) begin
					r_we    = 1'b1;
					r_waddr = AWM'(t_q[TW-1:0]) * AWM'(MAX_PIVOTS) + AWM'(sq_q[PW-1:0]);
					r_wdata = sat_add(r_rd, 32'(b_rd));
					state_d = S_MTRD;
				end else begin
					state_d = S_MTSTART;
				end
			end
			S_MTSTART: begin
				div_start = 1'b1;
				state_d   = S_MTDIV;
			end
			S_MTDIV: begin
				if (div_stat.done) begin
					r_we    = 1'b1;
					r_waddr = AWM'(t_q[TW-1:0]) * AWM'(MAX_PIVOTS) + AWM'(sq_q[PW-1:0]);
					r_wdata = sat_add(r_hold_q, div_stat.quot);
					state_d = S_MTRD;
				end
			end
			S_MADV: state_d = S_MCHK;
			S_LCHK: state_d = (qt_q < ns2_q && nf_q != '0) ? S_LTCHK : S_PT;
			S_LTCHK: state_d = (t_q < ntgt_q) ? S_LBDAT : S_LCHK;
			S_LBDAT: begin
				div_start = 1'b1;
				state_d   = S_LDIV;
			end
			S_LDIV: begin
				if (div_stat.done) begin
					state_d = S_LQRD;
				end
			end
			S_LQRD: state_d = (q_q < nf_q) ? S_LQWR : S_LTCHK;
			S_LQWR: begin
				r_we    = 1'b1;
				r_wdata = sat_add(r_rd, 32'(gift_q));
				state_d = S_LQRD;
			end
			S_PT: state_d = (t_q < ntgt_q) ? S_PS : S_DONE;
			S_PS: state_d = (s_q < nsrc_q) ? S_PQ : S_PT;
			S_PQ: state_d = (q_q < nf_q) ? S_PMUL : S_PWR;
			S_PMUL: state_d = S_PACC;
			S_PACC: state_d = S_PQ;
			S_PWR: begin
				c_we    = 1'b1;
				c_wdata = (acc_sh > ACCW'(VAL_MAX)) ? VAL_MAX : acc_sh[15:0];
				state_d = S_PS;
			end
			S_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register, response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			c_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= req_acc && (req_data.req_type == REQ_READ_C);
			if (req_acc && req_data.req_type == REQ_COMPUTE) begin
				c_valid_q <= 1'b1;
			end
			if (rd_s1 || (state_q == S_DONE && state_d == S_IDLE)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			rd_ok_s1 <= c_valid_q && (32'(req_data.row_index) < 32'(MAX_TOKENS)) &&
				(32'(req_data.col_index) < 32'(MAX_TOKENS));
		end
		if (rd_s1) begin
			out_q.result_kind  <= 1'b1;
			out_q.result_value <= rd_ok_s1 ? c_rd : 16'd0;
			out_q.status_code  <= ST_OK;
		end else if (state_q == S_DONE && state_d == S_IDLE) begin
			out_q.result_kind  <= 1'b0;
			out_q.result_value <= 16'd0;
			out_q.status_code  <= no_ov_q ? ST_NO_OVERLAP :
				(not_done_q ? ST_NOT_EXHAUSTED : ST_OK);
		end
	end

	// loop counters and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q       <= '0;
			qt_q       <= '0;
			q_q        <= '0;
			t_q        <= '0;
			s_q        <= '0;
			clr_q      <= '0;
			no_ov_q    <= 1'b0;
			not_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req_data.req_type == REQ_COMPUTE) begin
						clr_q   <= '0;
						sq_q    <= '0;
						qt_q    <= '0;
						t_q     <= '0;
						no_ov_q <= 1'b0;
					end
				end
				S_CLR: clr_q <= clr_q + 1'b1;
				S_MCHK: begin
					t_q        <= '0;
					not_done_q <= sq_q < nf_q;
				end
				S_MEVAL: begin
					if (!ev_exact && !ev_overlap) begin
						no_ov_q <= 1'b1;
					end
				end
				S_MTDAT: begin
					if (whole_q) begin
						t_q <= t_q + 1'b1;
					end
				end
				S_MTDIV: begin
					if (div_stat.done) begin
						t_q <= t_q + 1'b1;
					end
				end
				S_MADV: begin
					// advance the pointer whose range ends first, both on a tie
					if (fe_eq_q) begin
						sq_q <= sq_q + 1'b1;
						qt_q <= qt_q + 1'b1;
					end else if (fe_gt_q) begin
						qt_q <= qt_q + 1'b1;
					end else begin
						sq_q <= sq_q + 1'b1;
					end
				end
				S_LCHK: t_q <= '0;
				S_LTCHK: begin
					if (!(t_q < ntgt_q)) begin
						qt_q <= qt_q + 1'b1;
						t_q  <= '0;
					end
				end
				S_LDIV: q_q <= '0;
				S_LQRD: begin
					if (!(q_q < nf_q)) begin
						t_q <= t_q + 1'b1;
					end
				end
				S_LQWR: q_q <= q_q + 1'b1;
				S_PT: begin
					s_q <= '0;
					q_q <= '0;
				end
				S_PS: begin
					q_q <= '0;
					if (!(s_q < nsrc_q)) begin
						t_q <= t_q + 1'b1;
					end
				end
				S_PACC: q_q <= q_q + 1'b1;
				S_PWR: s_q <= s_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers of the compute
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_acc && req_data.req_type == REQ_COMPUTE) begin
			nf_q   <= (32'(req_data.first_pivot_count) > 32'(MAX_PIVOTS)) ?
				PCW'(MAX_PIVOTS) : PCW'(req_data.first_pivot_count);
			ns2_q  <= (32'(req_data.second_pivot_count) > 32'(MAX_PIVOTS)) ?
				PCW'(MAX_PIVOTS) : PCW'(req_data.second_pivot_count);
			nsrc_q <= (32'(req_data.source_token_count) > 32'(MAX_TOKENS)) ?
				TCW'(MAX_TOKENS) : TCW'(req_data.source_token_count);
			ntgt_q <= (32'(req_data.target_token_count) > 32'(MAX_TOKENS)) ?
				TCW'(MAX_TOKENS) : TCW'(req_data.target_token_count);
		end
		if (state_q == S_MEVAL) begin
			whole_q <= ev_exact;
			ov_q    <= right - left;
			len_q   <= se - sb;
			fe_eq_q <= fe == se;
			fe_gt_q <= fe > se;
		end
		if (state_q == S_MTDAT) begin
			prod_q   <= 32'(ov_q) * 32'(b_rd);
			r_hold_q <= r_rd;
		end
		if (state_q == S_LDIV && div_stat.done) begin
			gift_q <= div_stat.quot[15:0];
		end
		if (state_q == S_PMUL) begin
			prod_q <= 32'(a_rd) * 32'(r_rd);
		end
		if (state_q == S_PS) begin
			acc_q <= '0;
		end else if (state_q == S_PACC) begin
			acc_q <= acc_q + ACCW'(prod_q);
		end
	end

	apr_ram #(.DEPTH(MAX_PIVOTS), .WIDTH(32)) u_first (
		.clk(clk), .we(fr_we), .waddr(rng_waddr), .wdata(rng_wdata),
		.raddr(sq_q[PW-1:0]), .rdata(fr_rd)
	);

	apr_ram #(.DEPTH(MAX_PIVOTS), .WIDTH(32)) u_second (
		.clk(clk), .we(sr_we), .waddr(rng_waddr), .wdata(rng_wdata),
		.raddr(qt_q[PW-1:0]), .rdata(sr_rd)
	);

	apr_ram #(.DEPTH(MDEP), .WIDTH(16)) u_amat (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(req_data.prob_value),
		.raddr(a_raddr), .rdata(a_rd)
	);

	apr_ram #(.DEPTH(MDEP), .WIDTH(16)) u_bmat (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(req_data.prob_value),
		.raddr(b_raddr), .rdata(b_rd)
	);

	apr_ram #(.DEPTH(MDEP), .WIDTH(16)) u_rmat (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rd)
	);

	apr_ram #(.DEPTH(CDEP), .WIDTH(16)) u_cmat (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rd)
	);

	apr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .stat(div_stat)
	);

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

`ifndef ASSERT_OFF
	// a read request is only accepted when the response register is free or being taken
	a_rd_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> !out_valid_q) else $error("read data with response register full");

	// the divider only finishes while a wait state expects it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_MTDIV || state_q == S_LDIV))
		else $error("divider result not expected");

	// R and C are written only during a compute
	a_idle_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!r_we && !c_we)) else $error("matrix write while idle");
`endif
endmodule
`default_nettype wire

/* hw/rtl/apr_ram.sv */
`default_nettype none
module apr_ram #(
	parameter int DEPTH = apr_pkg::MAX_PIVOTS_DEF,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/apr_div.sv */
`default_nettype none
module apr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [apr_pkg::DIV_NW-1:0] num,
	input  wire logic [apr_pkg::DIV_DW-1:0] den,
	output apr_pkg::div_stat_t              stat
);
	import apr_pkg::*;

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic              ge;
	logic [DIV_DW:0]   rem_nx;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {r_q, n_q[DIV_NW-1]};
		ge     = rem_sh >= {1'b0, d_q};
		rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[DIV_NW-2:0], ge};
			r_q <= rem_nx[DIV_DW-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.quot = n_q;
endmodule
`default_nettype wire

/* dv/alignment_pivot_remap_tb.sv */
`default_nettype none
module alignment_pivot_remap_tb;
	import apr_pkg::*;

	localparam int NP = 64;
	localparam int NT = 64;
	localparam int FRAC = 15;
	localparam longint unsigned CYCLE_LIMIT = 3000000;
	// request codes the block does not know
	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	alignment_pivot_remap dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always #4 clk = ~clk;

	// shadow state of the remapper
	logic [31:0] first_rng [NP];
	logic [31:0] second_rng [NP];
	logic [15:0] a_mat [NP][NT];
	logic [15:0] b_mat [NT][NP];
	logic [15:0] r_mat [NT][NP];
	logic [15:0] c_mat [NT][NT];

	req_t request_backlog[$];
	rsp_t pending_results[$];
	int errors = 0;
	longint unsigned cycles = 0;
	bit running = 1'b0;
	bit idle_on = 1'b1;
	int gap_left = 0;
	int hold_left = 0;

	function automatic logic [15:0] sat_add(logic [15:0] d, longint unsigned add);
		longint unsigned s;
		s = 64'(d) + add;
		return (s > 65535) ? 16'hFFFF : s[15:0];
	endfunction

	function automatic int clamp_cnt(logic [6:0] v, int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	// append to the request backlog
	task automatic queue_req(req_t rq);
		request_backlog = {request_backlog, rq};
	endtask

	// merge the two range lists into R, then form C = R.A
	function automatic status_code_t remap_and_multiply(int nf, int ns2, int nsrc, int ntgt);
		int sq, qt;
		bit no_ov;
		longint unsigned fb, fe, sb, se, lft, rgt, ov, len, gift, acc, v;
		sq = 0;
		qt = 0;
		no_ov = 1'b0;
		for (int t = 0; t < NT; t++) begin
			for (int p = 0; p < NP; p++) r_mat[t][p] = '0;
			for (int s = 0; s < NT; s++) c_mat[t][s] = '0;
		end
		while (sq < nf && qt < ns2) begin
			fb = 64'(first_rng[sq][15:0]);
			fe = 64'(first_rng[sq][31:16]);
			sb = 64'(second_rng[qt][15:0]);
			se = 64'(second_rng[qt][31:16]);
			if (fb == sb && fe == se) begin
				for (int t = 0; t < ntgt; t++)
					r_mat[t][sq] = sat_add(r_mat[t][sq], 64'(b_mat[t][qt]));
				sq++;
				qt++;
			end else begin
				lft = (fb > sb) ? fb : sb;
				rgt = (fe < se) ? fe : se;
				if (lft < rgt) begin
					ov = rgt - lft;
					len = se - sb;
					for (int t = 0; t < ntgt; t++)
						r_mat[t][sq] = sat_add(r_mat[t][sq], ov * 64'(b_mat[t][qt]) / len);
				end else begin
					no_ov = 1'b1;
				end
				if (fe == se) begin
					sq++;
					qt++;
				end else if (fe > se) begin
					qt++;
				end else begin
					sq++;
				end
			end
		end
		// spread leftover second ranges evenly
		if (nf != 0) begin
			for (int q2 = qt; q2 < ns2; q2++)
				for (int t = 0; t < ntgt; t++) begin
					gift = 64'(b_mat[t][q2]) / 64'(nf);
					for (int q = 0; q < nf; q++) r_mat[t][q] = sat_add(r_mat[t][q], gift);
				end
		end
		for (int t = 0; t < ntgt; t++)
			for (int s = 0; s < nsrc; s++) begin
				acc = 0;
				for (int q = 0; q < nf; q++) acc += 64'(a_mat[q][s]) * 64'(r_mat[t][q]);
				v = acc >> FRAC;
				c_mat[t][s] = (v > 65535) ? 16'hFFFF : v[15:0];
			end
		if (no_ov) return ST_NO_OVERLAP;
		return (sq < nf) ? ST_NOT_EXHAUSTED : ST_OK;
	endfunction

	// update shadow state and queue the response a request causes
	function automatic void apply_request(req_t rq);
		rsp_t r;
		r = '0;
		case (rq.req_type)
			REQ_LOAD_FIRST: first_rng[rq.row_index] = {rq.range_end, rq.range_begin};
			REQ_LOAD_SECOND: second_rng[rq.row_index] = {rq.range_end, rq.range_begin};
			REQ_LOAD_A: a_mat[rq.row_index][rq.col_index] = rq.prob_value;
			REQ_LOAD_B: b_mat[rq.row_index][rq.col_index] = rq.prob_value;
			REQ_COMPUTE: begin
				r.status_code = remap_and_multiply(clamp_cnt(rq.first_pivot_count, NP),
					clamp_cnt(rq.second_pivot_count, NP),
					clamp_cnt(rq.source_token_count, NT),
					clamp_cnt(rq.target_token_count, NT));
				pending_results = {pending_results, r};
			end
			REQ_READ_C: begin
				r.result_kind = 1'b1;
				r.result_value = c_mat[rq.row_index][rq.col_index];
				pending_results = {pending_results, r};
			end
			default: ;
		endcase
	endfunction

	function automatic req_t noise_req(logic [2:0] code);
		logic [95:0] raw;
		req_t rq;
		raw = {$urandom(), $urandom(), $urandom()};
		rq = raw[$bits(req_t)-1:0];
		rq.req_type = code;
		return rq;
	endfunction

	task automatic push_range(req_code_t code, int idx, int b, int e);
		req_t rq;
		rq = noise_req(code);
		rq.row_index = 6'(idx);
		rq.range_begin = 16'(b);
		rq.range_end = 16'(e);
		queue_req(rq);
	endtask

	task automatic push_prob(req_code_t code, int row, int col, bit heavy);
		req_t rq;
		rq = noise_req(code);
		rq.row_index = 6'(row);
		rq.col_index = 6'(col);
		if (heavy || $urandom_range(0, 4) == 0) rq.prob_value = 16'd32768;
		else rq.prob_value = 16'($urandom_range(0, 32768));
		queue_req(rq);
	endtask

	task automatic push_compute(int nf, int ns2, int ns, int nt);
		req_t rq;
		rq = noise_req(REQ_COMPUTE);
		rq.first_pivot_count = 7'(nf);
		rq.second_pivot_count = 7'(ns2);
		rq.source_token_count = 7'(ns);
		rq.target_token_count = 7'(nt);
		queue_req(rq);
	endtask

	task automatic push_read(int row, int col);
		req_t rq;
		rq = noise_req(REQ_READ_C);
		rq.row_index = 6'(row);
		rq.col_index = 6'(col);
		queue_req(rq);
	endtask

	// one sentence: load everything the compute touches, compute, read back
	task automatic add_sentence(int nf, int ns2, int ns, int nt, int shape, bit heavy);
		int fb[NP];
		int fe[NP];
		int pos, len, rb, re;
		pos = $urandom_range(0, 2000);
		for (int i = 0; i < nf; i++) begin
			len = $urandom_range(1, 8);
			fb[i] = pos;
			fe[i] = pos + len;
			pos = fe[i] + (($urandom_range(0, 5) == 0) ? 1 : 0);
			push_range(REQ_LOAD_FIRST, i, fb[i], fe[i]);
		end
		pos = (nf > 0) ? fb[0] : $urandom_range(0, 2000);
		for (int i = 0; i < ns2; i++) begin
			if (shape == 0 && i < nf) begin
				rb = fb[i];
				re = fe[i];
			end else if (shape == 2) begin
				rb = $urandom_range(0, 65535);
				re = $urandom_range(0, 65535);
			end else begin
				rb = pos;
				re = pos + $urandom_range(1, 10);
				pos = re;
			end
			push_range(REQ_LOAD_SECOND, i, rb, re);
		end
		for (int q = 0; q < nf; q++)
			for (int s = 0; s < ns; s++) push_prob(REQ_LOAD_A, q, s, heavy);
		for (int t = 0; t < nt; t++)
			for (int q = 0; q < ns2; q++) push_prob(REQ_LOAD_B, t, q, heavy);
		if ($urandom_range(0, 3) == 0) queue_req(noise_req(REQ_UNKNOWN_LO));
		push_compute(nf, ns2, ns, nt);
		for (int k = $urandom_range(2, 8); k > 0; k--) begin
			if ($urandom_range(0, 4) == 0 || nt == 0 || ns == 0)
				push_read($urandom_range(0, 63), $urandom_range(0, 63));
			else
				push_read($urandom_range(0, nt - 1), $urandom_range(0, ns - 1));
		end
	endtask

	// driver: present requests, predict each one as it is accepted
	always @(posedge clk) begin
		if (running) begin
			if (req_valid && !req_stall) apply_request(req_data);
			if (req_valid && req_stall) begin
				// hold the stalled request
			end else if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_backlog.size() != 0) begin
				req_data <= request_backlog.pop_front();
				req_valid <= 1'b1;
				gap_left <= idle_on ? $urandom_range(0, 6) : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor: check responses in order, stall the response side at random
	always @(posedge clk) begin
		if (running) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp_data);
					errors++;
				end else begin
					rsp_t ex;
					ex = pending_results.pop_front();
					if (rsp_data.result_kind !== ex.result_kind) begin
						$display("%0t: result_kind expected %0d actual %0d", $time,
							ex.result_kind, rsp_data.result_kind);
						errors++;
					end
					if (rsp_data.result_value !== ex.result_value) begin
						$display("%0t: result_value expected %0d actual %0d", $time,
							ex.result_value, rsp_data.result_value);
						errors++;
					end
					if (rsp_data.status_code !== ex.status_code) begin
						$display("%0t: status_code expected %0d actual %0d", $time,
							ex.status_code, rsp_data.status_code);
						errors++;
					end
				end
				hold_left = idle_on ? $urandom_range(0, 6) : 0;
			end else if (hold_left > 0) begin
				hold_left = hold_left - 1;
			end
			rsp_stall <= (hold_left != 0);
		end
	end

	// watchdog, and switch idling on and off in stretches
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 400 == 0) idle_on <= ($urandom_range(0, 2) != 0);
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int nf, ns2, ns, nt;
		// C reads as zero until the first compute
		for (int t = 0; t < NT; t++)
			for (int s = 0; s < NT; s++) c_mat[t][s] = '0;
		// directed: read before any compute, unknown requests
		push_read(0, 0);
		push_read(63, 63);
		queue_req(noise_req(REQ_UNKNOWN_LO));
		queue_req(noise_req(REQ_UNKNOWN_HI));
		// oversized first count, extreme range bounds
		for (int i = 0; i < NP; i++)
			push_range(REQ_LOAD_FIRST, i, (i % 2) ? 0 : 65535, (i % 2) ? 65535 : 0);
		push_compute(127, 0, 0, 0);
		// oversized second count with no first pivots: nothing spreads
		for (int i = 0; i < NP; i++) push_range(REQ_LOAD_SECOND, i, i, i + 1);
		push_compute(0, 127, 127, 127);
		push_read(63, 63);
		// saturation through exact matches at full probability
		add_sentence(4, 4, 3, 3, 0, 1'b1);
		// partial overlaps, leftovers, no-overlap pairs
		add_sentence(3, 6, 2, 2, 1, 1'b0);
		add_sentence(3, 3, 2, 2, 2, 1'b0);
		add_sentence(0, 0, 0, 0, 0, 1'b0);
		while (request_backlog.size() < 560) begin
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
			ns2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4);
			ns = $urandom_range(0, 4);
			nt = $urandom_range(0, 4);
			add_sentence(nf, ns2, ns, nt, $urandom_range(0, 2), $urandom_range(0, 5) == 0);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running <= 1'b1;
		@(posedge clk);
		while (request_backlog.size() != 0 || req_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/apr_pkg.sv
hw/rtl/apr_ram.sv
hw/rtl/apr_div.sv
hw/rtl/alignment_pivot_remap.sv
dv/alignment_pivot_remap_tb.sv
